### design/sjrc_pkg.sv
// Shared types and codes for the shredder jam retry controller.
// No dependencies; the controller, torque and core files import this package.
package sjrc_pkg;

  // Operation codes carried by an input word.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Drive mode codes, also reported as the command field.
  localparam logic [2:0] M_STOP  = 3'd0;
  localparam logic [2:0] M_FWD   = 3'd1;
  localparam logic [2:0] M_DWELL = 3'd2;
  localparam logic [2:0] M_RSTOP = 3'd3;
  localparam logic [2:0] M_REV   = 3'd4;
  localparam logic [2:0] M_FAULT = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_NO_LOAD   = 3'd0;
  localparam logic [2:0] REG_GAIN      = 3'd1;
  localparam logic [2:0] REG_CAL       = 3'd2;
  localparam logic [2:0] REG_RUN_RPM   = 3'd3;
  localparam logic [2:0] REG_REV_TIME  = 3'd4;
  localparam logic [2:0] REG_RETRY_LIM = 3'd5;
  localparam logic [2:0] REG_TRIP      = 3'd6;
  localparam logic [2:0] REG_OVL_TIME  = 3'd7;

  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [23:0] TRIP_RESET = 24'hFFFFFF;

  // Scale of the speed deficit percentage.
  localparam logic [16:0] PERCENT_SCALE = 17'd100;

  typedef struct packed {
    logic [15:0] no_load_current_ma;
    logic [15:0] torque_gain;
    logic        calibrated;
    logic [7:0]  run_rpm;
    logic [15:0] reverse_time_ms;
    logic [7:0]  retry_limit;
    logic [23:0] trip_torque_mnm;
    logic [15:0] overload_time_ms;
  } sjrc_cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [15:0] current_ma;
    logic [9:0]  cutter_speed_rpm;
    logic        permission_ok;
    logic        heater_or_screw_on;
    logic        lockout_confirmed;
  } sjrc_item_t;

  // Item after the torque stage.
  typedef struct packed {
    sjrc_item_t  item;
    logic [23:0] torque;
  } sjrc_tq_item_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  drive_rpm;
    logic [7:0]  retries_done;
    logic [23:0] torque_estimate_mnm;
    logic        accepted;
  } sjrc_result_t;

endpackage

### design/sjrc_ifs.sv
// Valid/ready channel interfaces for input and result words.
// Depends on nothing; field widths follow the controller's item format.
interface sjrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic [15:0] current_ma;
  logic [9:0]  cutter_speed_rpm;
  logic        permission_ok;
  logic        heater_or_screw_on;
  logic        lockout_confirmed;

  modport source (
    output valid, op, now_ms, current_ma, cutter_speed_rpm,
           permission_ok, heater_or_screw_on, lockout_confirmed,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, current_ma, cutter_speed_rpm,
           permission_ok, heater_or_screw_on, lockout_confirmed,
    output ready
  );
endinterface

interface sjrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  drive_rpm;
  logic [7:0]  retries_done;
  logic [23:0] torque_estimate_mnm;
  logic        accepted;

  modport source (
    output valid, command, drive_rpm, retries_done, torque_estimate_mnm, accepted,
    input  ready
  );
  modport sink (
    input  valid, command, drive_rpm, retries_done, torque_estimate_mnm, accepted,
    output ready
  );
endinterface

### design/shredder_jam_retry_controller.sv
// Shredder jam retry controller. One result word is returned for every input
// word, in order, and is presented on the channel from the result register;
// a new word is taken every cycle unless a result word is stalled, so sustained
// throughput is one word per clock. The pipeline is an
// input register, the torque multiply stage and the mode sequencer with its
// result register; all stages advance together whenever the result register
// is empty or its word is being taken. Configuration is written through
// cfg_we/cfg_index/cfg_data and should change only while no word is in flight.
// Depends on sjrc_pkg, sjrc_ifs, sjrc_torque and sjrc_core.
module shredder_jam_retry_controller
  import sjrc_pkg::*;
#(
  parameter int unsigned RETRY_STOP_MS         = 200,
  parameter int unsigned STARTUP_GRACE_MS      = 1000,
  parameter int unsigned SENSOR_SAT_MA         = 30000,
  parameter int unsigned SPEED_DEFICIT_PERCENT = 50
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sjrc_in_if.sink               item_in,
  sjrc_out_if.source            result_out
);

  sjrc_cfg_t     cfg;
  logic          advance;
  logic          s0_valid;
  sjrc_item_t    s0_item;
  logic          s1_valid;
  sjrc_tq_item_t s1_word;
  logic          res_valid;
  sjrc_result_t  res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_load_current_ma <= 16'd0;
      cfg.torque_gain        <= 16'd0;
      cfg.calibrated         <= 1'b0;
      cfg.run_rpm            <= 8'd0;
      cfg.reverse_time_ms    <= 16'd0;
      cfg.retry_limit        <= 8'd0;
      cfg.trip_torque_mnm    <= TRIP_RESET;
      cfg.overload_time_ms   <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NO_LOAD:   cfg.no_load_current_ma <= cfg_data[15:0];
        REG_GAIN:      cfg.torque_gain        <= cfg_data[15:0];
        REG_CAL:       cfg.calibrated         <= cfg_data[0];
        REG_RUN_RPM:   cfg.run_rpm            <= cfg_data[7:0];
        REG_REV_TIME:  cfg.reverse_time_ms    <= cfg_data[15:0];
        REG_RETRY_LIM: cfg.retry_limit        <= cfg_data[7:0];
        REG_TRIP:      cfg.trip_torque_mnm    <= cfg_data[23:0];
        REG_OVL_TIME:  cfg.overload_time_ms   <= cfg_data[15:0];
        default:       cfg.calibrated         <= cfg.calibrated;
      endcase
    end
  end

  // The whole pipeline moves when the result register can take a word.
  assign advance       = !res_valid || result_out.ready;
  assign item_in.ready = advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_item.op                 <= item_in.op;
      s0_item.now_ms             <= item_in.now_ms;
      s0_item.current_ma         <= item_in.current_ma;
      s0_item.cutter_speed_rpm   <= item_in.cutter_speed_rpm;
      s0_item.permission_ok      <= item_in.permission_ok;
      s0_item.heater_or_screw_on <= item_in.heater_or_screw_on;
      s0_item.lockout_confirmed  <= item_in.lockout_confirmed;
    end
  end

  sjrc_torque u_torque (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cfg       (cfg),
    .in_valid  (s0_valid),
    .in_item   (s0_item),
    .out_valid (s1_valid),
    .out_word  (s1_word)
  );

  sjrc_core #(
    .RETRY_STOP_MS         (RETRY_STOP_MS),
    .STARTUP_GRACE_MS      (STARTUP_GRACE_MS),
    .SENSOR_SAT_MA         (SENSOR_SAT_MA),
    .SPEED_DEFICIT_PERCENT (SPEED_DEFICIT_PERCENT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cfg       (cfg),
    .in_valid  (s1_valid),
    .in_word   (s1_word),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result channel.
  assign result_out.valid               = res_valid;
  assign result_out.command             = res.command;
  assign result_out.drive_rpm           = res.drive_rpm;
  assign result_out.retries_done        = res.retries_done;
  assign result_out.torque_estimate_mnm = res.torque_estimate_mnm;
  assign result_out.accepted            = res.accepted;

  // A stalled result word holds back the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.ready) |-> !item_in.ready)
    else $error("input accepted while result word is stalled");

  // Stopped, retry stop and fault latched never drive the motor.
  a_idle_modes_no_speed: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && (result_out.command == M_FAULT ||
                          result_out.command == M_STOP ||
                          result_out.command == M_RSTOP))
    |-> (result_out.drive_rpm == 8'd0))
    else $error("nonzero drive speed in a stopped mode");

  // A start refused while uncalibrated; an uncalibrated drive reports no torque.
  a_uncal_no_torque: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !cfg.calibrated) |-> (result_out.torque_estimate_mnm == 24'd0))
    else $error("torque reported without calibration");

endmodule

### design/sjrc_torque.sv
// Torque estimation stage: one 16x16 multiply, registered with the word.
// Depends on sjrc_pkg.
module sjrc_torque
  import sjrc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  sjrc_cfg_t     cfg,
  input  logic          in_valid,
  input  sjrc_item_t    in_item,
  output logic          out_valid,
  output sjrc_tq_item_t out_word
);

  logic [15:0] load_ma;
  logic [31:0] product;

  // Load current above no-load, clamped at zero, times the Q8.8 gain.
  always_comb begin
    load_ma = (in_item.current_ma > cfg.no_load_current_ma) ?
              (in_item.current_ma - cfg.no_load_current_ma) : 16'd0;
    product = {16'd0, load_ma} * {16'd0, cfg.torque_gain};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word.item   <= in_item;
      out_word.torque <= cfg.calibrated ? product[31:8] : 24'd0;
    end
  end

endmodule

### design/sjrc_core.sv
// Mode sequencer: applies one command word to the controller state and
// registers the result word. Depends on sjrc_pkg.
module sjrc_core
  import sjrc_pkg::*;
#(
  parameter int unsigned RETRY_STOP_MS         = 200,
  parameter int unsigned STARTUP_GRACE_MS      = 1000,
  parameter int unsigned SENSOR_SAT_MA         = 30000,
  parameter int unsigned SPEED_DEFICIT_PERCENT = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  sjrc_cfg_t     cfg,
  input  logic          in_valid,
  input  sjrc_tq_item_t in_word,
  output logic          res_valid,
  output sjrc_result_t  res
);

  // Controller state.
  logic [2:0]  mode;
  logic [7:0]  retries;
  logic        overload_flag;
  logic [31:0] forward_start_time;
  logic [31:0] overload_start_time;
  logic [31:0] stop_deadline;
  logic [31:0] reverse_deadline;

  logic [2:0]  mode_next;
  logic [7:0]  retries_next;
  logic        overload_flag_next;
  logic [31:0] forward_start_time_next;
  logic [31:0] overload_start_time_next;
  logic [31:0] stop_deadline_next;
  logic [31:0] reverse_deadline_next;
  logic        acc;
  logic [7:0]  rpm;

  logic [31:0] now;
  logic        interlock_ok;
  logic        past_grace;
  logic        slow;
  logic        over;
  logic        dwell_done;
  logic [2:0]  mode_cur;

  // Overload detection, evaluated in parallel with the sequencer.
  always_comb begin
    now          = in_word.item.now_ms;
    interlock_ok = in_word.item.permission_ok && !in_word.item.heater_or_screw_on;
    past_grace   = (now - forward_start_time) >= 32'(STARTUP_GRACE_MS);
    slow         = ({7'd0, in_word.item.cutter_speed_rpm} * PERCENT_SCALE) <
                   (17'(SPEED_DEFICIT_PERCENT) * {9'd0, cfg.run_rpm});
    over         = past_grace &&
                   ((in_word.torque >= cfg.trip_torque_mnm) ||
                    ((in_word.item.current_ma >= 16'(SENSOR_SAT_MA)) && slow));
    dwell_done   = (now - overload_start_time) >= {16'd0, cfg.overload_time_ms};
    // Codes beyond fault latched behave as stop.
    mode_cur     = (mode > M_FAULT) ? M_STOP : mode;
  end

  // Next state for one word.
  always_comb begin
    mode_next                = mode_cur;
    retries_next             = retries;
    overload_flag_next       = overload_flag;
    forward_start_time_next  = forward_start_time;
    overload_start_time_next = overload_start_time;
    stop_deadline_next       = stop_deadline;
    reverse_deadline_next    = reverse_deadline;
    acc                      = 1'b1;

    unique case (in_word.item.op)
      OP_TICK: begin
        if (mode_cur == M_FWD || mode_cur == M_DWELL ||
            mode_cur == M_RSTOP || mode_cur == M_REV) begin
          if (!interlock_ok) begin
            mode_next          = M_FAULT;
            overload_flag_next = 1'b0;
          end else if (mode_cur == M_RSTOP) begin
            if (now >= stop_deadline) begin
              if (retries != 8'hFF) retries_next = retries + 8'd1;
              mode_next             = M_REV;
              reverse_deadline_next = now + {16'd0, cfg.reverse_time_ms};
            end
          end else if (mode_cur == M_REV) begin
            if (now >= reverse_deadline) begin
              if (retries >= cfg.retry_limit) begin
                mode_next          = M_FAULT;
                overload_flag_next = 1'b0;
              end else begin
                mode_next               = M_FWD;
                overload_flag_next      = 1'b0;
                forward_start_time_next = now;
              end
            end
          end else if (!over) begin
            overload_flag_next = 1'b0;
            mode_next          = M_FWD;
          end else if (!overload_flag) begin
            overload_flag_next       = 1'b1;
            overload_start_time_next = now;
            mode_next                = M_DWELL;
          end else if (dwell_done) begin
            mode_next          = M_RSTOP;
            stop_deadline_next = now + 32'(RETRY_STOP_MS);
            overload_flag_next = 1'b0;
          end
        end
      end
      OP_START: begin
        if (!cfg.calibrated || !interlock_ok || mode_cur == M_FAULT) begin
          acc = 1'b0;
        end else begin
          mode_next               = M_FWD;
          retries_next            = 8'd0;
          overload_flag_next      = 1'b0;
          forward_start_time_next = now;
        end
      end
      OP_STOP: begin
        mode_next          = M_STOP;
        overload_flag_next = 1'b0;
      end
      OP_CLEAR: begin
        if (mode_cur != M_FAULT || !in_word.item.lockout_confirmed || !interlock_ok) begin
          acc = 1'b0;
        end else begin
          mode_next          = M_STOP;
          overload_flag_next = 1'b0;
          retries_next       = 8'd0;
        end
      end
      default: begin
        acc = 1'b1;
      end
    endcase
  end

  // Drive speed for the resulting mode; reverse runs at half speed.
  always_comb begin
    case (mode_next)
      M_FWD, M_DWELL: rpm = cfg.run_rpm;
      M_REV:          rpm = cfg.run_rpm >> 1;
      default:        rpm = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= M_STOP;
      retries             <= 8'd0;
      overload_flag       <= 1'b0;
      forward_start_time  <= 32'd0;
      overload_start_time <= 32'd0;
      stop_deadline       <= 32'd0;
      reverse_deadline    <= 32'd0;
      res_valid           <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
      if (in_valid) begin
        mode                <= mode_next;
        retries             <= retries_next;
        overload_flag       <= overload_flag_next;
        forward_start_time  <= forward_start_time_next;
        overload_start_time <= overload_start_time_next;
        stop_deadline       <= stop_deadline_next;
        reverse_deadline    <= reverse_deadline_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      res.command             <= mode_next;
      res.drive_rpm           <= rpm;
      res.retries_done        <= retries_next;
      res.torque_estimate_mnm <= in_word.torque;
      res.accepted            <= acc;
    end
  end

endmodule
